[hw/rtl/chm_pkg.sv]
// chm_pkg: shared codes and controller/datapath interface types of the chained hash map
`default_nettype none

package chm_pkg;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;    // clear one head and one used bit
        logic latch;       // capture the transaction, start hashing
        logic walk_load;   // take the bucket head as first chain node
        logic walk_step;   // move to the next chain node
        logic wr_value;    // overwrite the value of the matching node
        logic unlink;      // take the matching node out of its chain
        logic scan_start;  // begin free slot scan at slot zero
        logic scan_step;   // probe the next slot
        logic alloc;       // fill the free slot
        logic link;        // hook the new slot onto the chain tail
        logic res_hit;     // result: found, old value
        logic res_miss;    // result: nothing found
        logic res_full;    // result: pool full
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic mod_rdy;
        logic mode_ins;
        logic mode_rem;
        logic mode_bad;
        logic head_none;
        logic cur_match;
        logic walk_end;
        logic pool_full;
        logic scan_free;
        logic clr_last;
    } sts_t;

endpackage

`default_nettype wire

[hw/rtl/chained_hash_map_unit.sv]
// chained_hash_map_unit: top level of the key-value map with per-bucket chains
//
//  channel   signals                           dir  transaction taken when
//  -------   -------------------------------   ---  ------------------------------
//  command   start, mode, key, payload, busy   in   start high while busy low
//  result    done, found, old_value, full_res  out  done high, one cycle, no stall
//
//  a get, replace or remove walks the chain node by node up to the match; a new insert
//    adds the free slot scan from slot zero up to the lowest free slot, then fills the
//    slot and links it; a non power of two bucket count adds the key remainder (fold,
//    then reciprocal multiply)
//  the chain walk reads one node per cycle from the single slot memory read port
//  reset: after rst_n rises a clearing pass over max(BUCKETS, ENTRIES) addresses empties
//    the bucket heads and used bits; busy stays high during it
//  the result receiver cannot stall; each result is shown once, for one cycle
`default_nettype none

module chained_hash_map_unit #(
    parameter int BUCKETS = 16,
    parameter int ENTRIES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // command transaction
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [chm_pkg::MODE_W-1:0]  mode,
    input  wire logic [chm_pkg::KEY_W-1:0]   key,
    input  wire logic [chm_pkg::VAL_W-1:0]   payload,
    // result transaction
    output logic                             done,
    output logic                             found,
    output logic [chm_pkg::VAL_W-1:0]        old_value,
    output logic                             full_res
);

    // command and status between controller and datapath
    chm_pkg::cmd_t cmd;
    chm_pkg::sts_t sts;

    // controller: clearing pass, hashing, chain walk, free slot scan, linking
    chm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: bucket head memory, slot pool memories, walk pointers, results
    chm_dp #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode),
        .key       (key),
        .payload   (payload),
        .done      (done),
        .found     (found),
        .old_value (old_value),
        .full_res  (full_res)
    );

endmodule

`default_nettype wire

[hw/rtl/chm_mod.sv]
// chm_mod: bucket index unit, key remainder by the bucket count
`default_nettype none

module chm_mod #(
    parameter int BUCKETS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [chm_pkg::KEY_W-1:0]     key,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket,
    output logic                               rdy
);

    localparam int HW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    logic [HW-1:0] rem_reg;
    logic          rdy_reg;

    generate
        if (IS_POW2) begin : g_pow2
            // power of two: the remainder is the low key bits
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rdy_reg <= 1'b0;
                end
                else if (start)
                begin
                    rdy_reg <= 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= key[HW-1:0] & HW'(BUCKETS - 1);
                end
            end
        end
        else
        begin : g_recip
            // fold the upper key half in with 2^16 mod BUCKETS, then reduce the
            // folded value by reciprocal multiplication; one step per cycle
            localparam int LO_W = chm_pkg::KEY_W / 2;
            localparam int Y_W  = 26;
            localparam int M_W  = 27;
            localparam int P_W  = Y_W + M_W;
            localparam logic [HW-1:0] FOLD = HW'((1 << LO_W) % BUCKETS);
            localparam longint RECIP_L = ((longint'(1) << (Y_W + HW)) +
                                          longint'(BUCKETS) - longint'(1)) /
                                         longint'(BUCKETS);
            localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

            logic [Y_W-1:0] y_reg;
            logic [Y_W-1:0] q_reg;
            logic           run1_reg;
            logic           run2_reg;
            logic [Y_W-1:0] fold_sum;
            logic [P_W-1:0] prod;
            logic [Y_W-1:0] rem_full;

            assign fold_sum = Y_W'(key[chm_pkg::KEY_W-1:LO_W]) * Y_W'(FOLD) +
                              Y_W'(key[LO_W-1:0]);
            assign prod     = P_W'(y_reg) * P_W'(RECIP);
            assign rem_full = y_reg - q_reg * Y_W'(BUCKETS);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run1_reg <= 1'b0;
                    run2_reg <= 1'b0;
                    rdy_reg  <= 1'b0;
                end
                else
                begin
                    run1_reg <= start;
                    run2_reg <= run1_reg;
                    if (start)
                    begin
                        rdy_reg <= 1'b0;
                    end
                    else if (run2_reg)
                    begin
                        rdy_reg <= 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    y_reg <= fold_sum;
                end
                if (run1_reg)
                begin
                    q_reg <= Y_W'(prod >> (Y_W + HW));
                end
                if (run2_reg)
                begin
                    rem_reg <= rem_full[HW-1:0];
                end
            end
        end
    endgenerate

    assign bucket = rem_reg;
    assign rdy    = rdy_reg;

endmodule

`default_nettype wire

[hw/rtl/chm_dp.sv]
// chm_dp: datapath of the chained hash map, bucket heads, slot pool and walk registers
`default_nettype none

module chm_dp #(
    parameter int BUCKETS = 16,
    parameter int ENTRIES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire chm_pkg::cmd_t               cmd,
    output chm_pkg::sts_t                    sts,
    input  wire logic [chm_pkg::MODE_W-1:0]  mode,
    input  wire logic [chm_pkg::KEY_W-1:0]   key,
    input  wire logic [chm_pkg::VAL_W-1:0]   payload,
    output logic                             done,
    output logic                             found,
    output logic [chm_pkg::VAL_W-1:0]        old_value,
    output logic                             full_res
);

    localparam int SW    = $clog2(ENTRIES + 1);
    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CLR_N = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
    localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam logic [SW-1:0] NONE = SW'(ENTRIES);

    // transaction registers
    logic [chm_pkg::MODE_W-1:0] mode_reg;
    logic [chm_pkg::KEY_W-1:0]  key_reg;
    logic [chm_pkg::VAL_W-1:0]  pay_reg;

    // walk and scan registers
    logic [SW-1:0] cur_reg;
    logic [SW-1:0] prev_reg;
    logic [SW-1:0] steps_reg;
    logic [IW-1:0] chk_reg;
    logic [SW-1:0] used_cnt_reg;
    logic [CW-1:0] clr_reg;

    // result registers
    logic                      done_reg;
    logic                      found_reg;
    logic [chm_pkg::VAL_W-1:0] old_reg;
    logic                      full_reg;

    // memories and their registered read data
    logic [SW-1:0]             head_mem [BUCKETS];
    logic                      used_mem [ENTRIES];
    logic [chm_pkg::KEY_W-1:0] key_mem  [ENTRIES];
    logic [chm_pkg::VAL_W-1:0] val_mem  [ENTRIES];
    logic [SW-1:0]             next_mem [ENTRIES];

    logic [SW-1:0]             rd_head_reg;
    logic                      rd_used_reg;
    logic [chm_pkg::KEY_W-1:0] rd_key_reg;
    logic [chm_pkg::VAL_W-1:0] rd_val_reg;
    logic [SW-1:0]             rd_next_reg;

    logic [HW-1:0] bkt;
    logic          mod_rdy;

    logic          clr_head_ok;
    logic          clr_used_ok;
    logic          prev_none;
    logic [IW-1:0] slot_raddr;

    logic          head_we;
    logic [HW-1:0] head_waddr;
    logic [SW-1:0] head_wdata;
    logic          used_we;
    logic [IW-1:0] used_waddr;
    logic          used_wdata;
    logic          next_we;
    logic [IW-1:0] next_waddr;
    logic [SW-1:0] next_wdata;
    logic          val_we;
    logic [IW-1:0] val_waddr;

    chm_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.latch),
        .key    (key),
        .bucket (bkt),
        .rdy    (mod_rdy)
    );

    assign clr_head_ok = ({1'b0, clr_reg} < (CW+1)'(BUCKETS));
    assign clr_used_ok = ({1'b0, clr_reg} < (CW+1)'(ENTRIES));
    assign prev_none   = (prev_reg >= NONE);

    // slot read address
    always_comb
    begin
        if (cmd.walk_load)
        begin
            slot_raddr = rd_head_reg[IW-1:0];
        end
        else if (cmd.walk_step)
        begin
            slot_raddr = rd_next_reg[IW-1:0];
        end
        else if (cmd.scan_start)
        begin
            slot_raddr = '0;
        end
        else if (cmd.scan_step)
        begin
            slot_raddr = chk_reg + IW'(1);
        end
        else
        begin
            slot_raddr = cur_reg[IW-1:0];
        end
    end

    // write port selection
    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = bkt;
        head_wdata = NONE;
        used_we    = 1'b0;
        used_waddr = cur_reg[IW-1:0];
        used_wdata = 1'b0;
        next_we    = 1'b0;
        next_waddr = prev_reg[IW-1:0];
        next_wdata = NONE;
        val_we     = 1'b0;
        val_waddr  = cur_reg[IW-1:0];

        if (cmd.clr_step)
        begin
            head_we    = clr_head_ok;
            head_waddr = clr_reg[HW-1:0];
            used_we    = clr_used_ok;
            used_waddr = clr_reg[IW-1:0];
        end

        if (cmd.wr_value)
        begin
            val_we = 1'b1;
        end

        if (cmd.unlink)
        begin
            used_we    = 1'b1;
            head_we    = prev_none;
            head_wdata = rd_next_reg;
            next_we    = !prev_none;
            next_wdata = rd_next_reg;
        end

        if (cmd.alloc)
        begin
            used_we    = 1'b1;
            used_waddr = chk_reg;
            used_wdata = 1'b1;
            next_we    = 1'b1;
            next_waddr = chk_reg;
            val_we     = 1'b1;
            val_waddr  = chk_reg;
        end

        if (cmd.link)
        begin
            head_we    = prev_none;
            head_wdata = SW'(chk_reg);
            next_we    = !prev_none;
            next_wdata = SW'(chk_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        rd_head_reg <= head_mem[bkt];
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        rd_used_reg <= used_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            key_mem[chk_reg] <= key_reg;
        end
        rd_key_reg <= key_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= pay_reg;
        end
        rd_val_reg <= val_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        rd_next_reg <= next_mem[slot_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            used_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cmd.alloc)
            begin
                used_cnt_reg <= used_cnt_reg + SW'(1);
            end
            else if (cmd.unlink)
            begin
                used_cnt_reg <= used_cnt_reg - SW'(1);
            end
            done_reg <= cmd.res_hit | cmd.res_miss | cmd.res_full;
        end
    end

    // transaction, walk, scan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            pay_reg  <= payload;
        end
        if (cmd.walk_load)
        begin
            cur_reg   <= rd_head_reg;
            prev_reg  <= NONE;
            steps_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= rd_next_reg;
            steps_reg <= steps_reg + SW'(1);
        end
        if (cmd.scan_start)
        begin
            chk_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            chk_reg <= chk_reg + IW'(1);
        end
        if (cmd.res_hit)
        begin
            found_reg <= 1'b1;
            old_reg   <= rd_val_reg;
            full_reg  <= 1'b0;
        end
        else if (cmd.res_miss | cmd.res_full)
        begin
            found_reg <= 1'b0;
            old_reg   <= '0;
            full_reg  <= cmd.res_full;
        end
    end

    always_comb
    begin
        sts.mod_rdy   = mod_rdy;
        sts.mode_ins  = (mode_reg == chm_pkg::MODE_INSERT);
        sts.mode_rem  = (mode_reg == chm_pkg::MODE_REMOVE);
        sts.mode_bad  = (mode_reg != chm_pkg::MODE_INSERT) &&
                        (mode_reg != chm_pkg::MODE_GET) &&
                        (mode_reg != chm_pkg::MODE_REMOVE);
        sts.head_none = (rd_head_reg >= NONE);
        sts.cur_match = rd_used_reg && (rd_key_reg == key_reg);
        sts.walk_end  = (rd_next_reg >= NONE) || ((steps_reg + SW'(1)) == NONE);
        sts.pool_full = (used_cnt_reg == NONE);
        sts.scan_free = !rd_used_reg;
        sts.clr_last  = (clr_reg == CW'(CLR_N - 1));
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign old_value = old_reg;
    assign full_res  = full_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_cnt_reg <= NONE)
        else $error("used slot count above pool size");

    a_link_after_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> $past(cmd.alloc))
        else $error("chain link without slot allocation");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

[hw/rtl/chm_ctrl.sv]
// chm_ctrl: controller state machine of the chained hash map
`default_nettype none

module chm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire chm_pkg::sts_t sts,
    output chm_pkg::cmd_t      cmd,
    output logic               busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_WALK,
        S_MISS,
        S_SCAN,
        S_ALLOC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   link_phase_reg;
    logic   link_phase_next;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        link_phase_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.mod_rdy)
                begin
                    if (sts.mode_bad)
                    begin
                        cmd.res_miss = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                cmd.walk_load = 1'b1;
                state_next    = sts.head_none ? S_MISS : S_WALK;
            end
            S_WALK:
            begin
                if (sts.cur_match)
                begin
                    cmd.res_hit  = 1'b1;
                    cmd.wr_value = sts.mode_ins;
                    cmd.unlink   = sts.mode_rem;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    if (sts.walk_end)
                    begin
                        state_next = S_MISS;
                    end
                end
            end
            S_MISS:
            begin
                if (!sts.mode_ins)
                begin
                    cmd.res_miss = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (sts.pool_full)
                begin
                    cmd.res_full = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_free)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_ALLOC:
            begin
                // the fill phase fills the slot, the link phase then links it
                if (!link_phase_reg)
                begin
                    cmd.alloc       = 1'b1;
                    link_phase_next = 1'b1;
                end
                else
                begin
                    cmd.link     = 1'b1;
                    cmd.res_miss = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            busy_reg       <= 1'b1;
            link_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= (state_next != S_IDLE);
            link_phase_reg <= link_phase_next;
        end
    end

    assign busy = busy_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("accepted transaction did not raise busy");

    a_alloc_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC && !link_phase_reg) |-> $past(state_reg == S_SCAN))
        else $error("slot allocation without free slot scan");

endmodule

`default_nettype wire
